### src/bitmap_trie_key_lookup_unit_assert.svh
// Assertion macros for the bitmap trie key lookup unit.
`ifndef BITMAP_TRIE_KEY_LOOKUP_UNIT_ASSERT_SVH
`define BITMAP_TRIE_KEY_LOOKUP_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BTKL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bitmap trie lookup check failed");

// Next-cycle implication, checked outside reset.
`define BTKL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bitmap trie lookup check failed");

`endif

### src/btkl_pkg.sv
// Shared types and constants for the bitmap trie key lookup unit.
`timescale 1ns / 1ps

package btkl_pkg;

    localparam int FULL_NODES = 4096;
    localparam int TERM_NODES = 4096;
    localparam int ADDR_W     = 12;
    localparam int IDX_W      = 13;
    localparam int TERM_BIT   = 12;
    localparam int BM_WORDS   = 4;
    localparam int WORD_W     = 64;
    localparam int ROW_W      = BM_WORDS * WORD_W;
    localparam int FREQ_W     = 32;
    localparam int POP_W      = 9;

    typedef enum logic [1:0] {
        KIND_BITMAP = 2'd0,
        KIND_LINK   = 2'd1,
        KIND_TERM   = 2'd2,
        KIND_KEY    = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [ADDR_W-1:0]  node_addr;
        logic [1:0]         word_sel;
        logic [WORD_W-1:0]  bitmap_word;
        logic [IDX_W-1:0]   child_link;
        logic [FREQ_W-1:0]  entry_freq;
        logic [7:0]         key_byte;
        logic               key_last;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic [FREQ_W-1:0]  freq_out;
        logic [IDX_W-1:0]   reached_index;
    } out_item_t;

    typedef struct packed {
        logic               bm_we;
        logic               link_we;
        logic [ADDR_W-1:0]  addr;
        logic [1:0]         wsel;
        logic [WORD_W-1:0]  bm_data;
        logic [IDX_W-1:0]   link;
        logic [FREQ_W-1:0]  freq;
    } node_wr_t;

    typedef struct packed {
        logic [ROW_W-1:0]   bitmap;
        logic [IDX_W-1:0]   link;
        logic [FREQ_W-1:0]  freq;
    } node_row_t;

    typedef struct packed {
        logic               present;
        logic [IDX_W-1:0]   index;
    } child_t;

endpackage

### src/btkl_node_mem.sv
// Full node memory: four bitmap word banks plus link and frequency, one row read per cycle.
`timescale 1ns / 1ps

module btkl_node_mem (
    input  logic                  aclk,
    input  btkl_pkg::node_wr_t    wr,
    input  logic                  rd_en,
    input  logic [btkl_pkg::ADDR_W-1:0] rd_addr,
    output btkl_pkg::node_row_t   rd_row
);
    import btkl_pkg::*;

    logic [WORD_W-1:0]          bm_mem [BM_WORDS][FULL_NODES];
    logic [IDX_W+FREQ_W-1:0]    lf_mem [FULL_NODES];
    node_row_t                  rd_row_reg;

    always_ff @(posedge aclk) begin
        for (int w = 0; w < BM_WORDS; w++) begin
            if (wr.bm_we && (wr.wsel == 2'(w))) begin
                bm_mem[w][wr.addr] <= wr.bm_data;
            end
        end
        if (wr.link_we) begin
            lf_mem[wr.addr] <= {wr.link, wr.freq};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            for (int w = 0; w < BM_WORDS; w++) begin
                rd_row_reg.bitmap[w*WORD_W +: WORD_W] <= bm_mem[w][rd_addr];
            end
            {rd_row_reg.link, rd_row_reg.freq} <= lf_mem[rd_addr];
        end
    end

    assign rd_row = rd_row_reg;

endmodule

### src/btkl_term_mem.sv
// Terminal entry frequency memory with a registered read.
`timescale 1ns / 1ps

module btkl_term_mem (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [btkl_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [btkl_pkg::FREQ_W-1:0]  wr_data,
    input  logic                         rd_en,
    input  logic [btkl_pkg::ADDR_W-1:0]  rd_addr,
    output logic [btkl_pkg::FREQ_W-1:0]  rd_data
);
    import btkl_pkg::*;

    logic [FREQ_W-1:0] mem [TERM_NODES];
    logic [FREQ_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/btkl_child_calc.sv
// Child presence test and child index from a node's bitmap row and first-child link.
`timescale 1ns / 1ps

module btkl_child_calc (
    input  logic [btkl_pkg::ROW_W-1:0]  bitmap,
    input  logic [btkl_pkg::IDX_W-1:0]  link,
    input  logic [7:0]                  key_byte,
    output btkl_pkg::child_t            child
);
    import btkl_pkg::*;

    logic [ROW_W-1:0]   below;
    logic [2:0]         nib   [ROW_W/4];
    logic [4:0]         grp16 [ROW_W/16];
    logic [6:0]         grp64 [BM_WORDS];
    logic [POP_W-1:0]   pops;

    always_comb begin
        for (int i = 0; i < ROW_W; i++) begin
            below[i] = bitmap[i] & (8'(i) < key_byte);
        end
        for (int n = 0; n < ROW_W/4; n++) begin
            nib[n] = {2'b00, below[4*n]} + {2'b00, below[4*n+1]}
                   + {2'b00, below[4*n+2]} + {2'b00, below[4*n+3]};
        end
        for (int g = 0; g < ROW_W/16; g++) begin
            grp16[g] = {2'b00, nib[4*g]} + {2'b00, nib[4*g+1]}
                     + {2'b00, nib[4*g+2]} + {2'b00, nib[4*g+3]};
        end
        for (int w = 0; w < BM_WORDS; w++) begin
            grp64[w] = {2'b00, grp16[4*w]} + {2'b00, grp16[4*w+1]}
                     + {2'b00, grp16[4*w+2]} + {2'b00, grp16[4*w+3]};
        end
        pops = {2'b00, grp64[0]} + {2'b00, grp64[1]}
             + {2'b00, grp64[2]} + {2'b00, grp64[3]};
    end

    assign child.present = bitmap[key_byte];
    assign child.index   = {link[TERM_BIT],
                            link[ADDR_W-1:0] + {{(ADDR_W-POP_W){1'b0}}, pops}};

endmodule

### src/bitmap_trie_key_lookup_unit.sv
// Top level of the bitmap trie key lookup unit: walk control and result register.
//
// Input channel s_valid/s_ready/s_data carries one item per handshake: a bitmap word
// write, a node link and frequency write, a terminal frequency write, or a key byte.
// Result channel m_valid/m_ready/m_data carries one item per key, issued on the byte
// marked last: found flag, frequency of the reached entry and its index.
// Write items produce nothing. A key byte that descends passes through the node row
// read (four bitmap words, link, frequency) and then the popcount and child index add.
// A byte after a miss, or on a terminal entry, skips both. The last byte adds a
// frequency read; when it descends, its result is registered from the emit state that
// follows the calc state. The node memory read and the 256-bit popcount set the rate.
// The result register holds one item; while it waits for m_ready the next key's bytes
// are still taken, and only the following result stalls until the slot frees.
// Reset returns the walk to the root and clears the result valid flag. Stored bitmaps,
// links and frequencies are not cleared and must be written before a key reaches them.
`timescale 1ns / 1ps
`include "bitmap_trie_key_lookup_unit_assert.svh"

module bitmap_trie_key_lookup_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  btkl_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output btkl_pkg::out_item_t   m_data
);
    import btkl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_EMIT
    } state_t;

    state_t             state_reg;
    logic [IDX_W-1:0]   walk_index_reg;
    logic               missed_reg;
    logic [7:0]         key_byte_reg;
    logic               key_last_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg;

    logic               s_fire;
    logic               key_fire;
    logic               emit_ok;
    node_wr_t           node_wr;
    logic               node_rd_en;
    logic [ADDR_W-1:0]  node_rd_addr;
    node_row_t          node_row;
    logic               term_rd_en;
    logic [FREQ_W-1:0]  term_rd_data;
    child_t             child;
    logic [FREQ_W-1:0]  freq_sel;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign key_fire = s_fire && (s_data.kind == KIND_KEY);
    assign emit_ok  = !m_valid_reg || m_ready;

    assign node_wr.bm_we   = s_fire && (s_data.kind == KIND_BITMAP);
    assign node_wr.link_we = s_fire && (s_data.kind == KIND_LINK);
    assign node_wr.addr    = s_data.node_addr;
    assign node_wr.wsel    = s_data.word_sel;
    assign node_wr.bm_data = s_data.bitmap_word;
    assign node_wr.link    = s_data.child_link;
    assign node_wr.freq    = s_data.entry_freq;

    always_comb begin
        node_rd_en   = 1'b0;
        node_rd_addr = walk_index_reg[ADDR_W-1:0];
        term_rd_en   = 1'b0;
        if (key_fire && !missed_reg && !walk_index_reg[TERM_BIT]) begin
            node_rd_en = 1'b1;
        end
        if ((state_reg == S_CALC) && key_last_reg && child.present) begin
            node_rd_addr = child.index[ADDR_W-1:0];
            node_rd_en   = !child.index[TERM_BIT];
            term_rd_en   = child.index[TERM_BIT];
        end
    end

    btkl_node_mem u_node_mem (
        .aclk    (aclk),
        .wr      (node_wr),
        .rd_en   (node_rd_en),
        .rd_addr (node_rd_addr),
        .rd_row  (node_row)
    );

    btkl_term_mem u_term_mem (
        .aclk    (aclk),
        .wr_en   (s_fire && (s_data.kind == KIND_TERM)),
        .wr_addr (s_data.node_addr),
        .wr_data (s_data.entry_freq),
        .rd_en   (term_rd_en),
        .rd_addr (child.index[ADDR_W-1:0]),
        .rd_data (term_rd_data)
    );

    btkl_child_calc u_child_calc (
        .bitmap   (node_row.bitmap),
        .link     (node_row.link),
        .key_byte (key_byte_reg),
        .child    (child)
    );

    assign freq_sel = walk_index_reg[TERM_BIT] ? term_rd_data : node_row.freq;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            walk_index_reg <= '0;
            missed_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (key_fire) begin
                        key_byte_reg <= s_data.key_byte;
                        key_last_reg <= s_data.key_last;
                        if (missed_reg || walk_index_reg[TERM_BIT]) begin
                            missed_reg <= 1'b1;
                            if (s_data.key_last) begin
                                state_reg <= S_EMIT;
                            end
                        end else begin
                            state_reg <= S_CALC;
                        end
                    end
                end
                S_CALC: begin
                    if (child.present) begin
                        walk_index_reg <= child.index;
                    end else begin
                        missed_reg <= 1'b1;
                    end
                    state_reg <= key_last_reg ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (emit_ok) begin
                        m_valid_reg              <= 1'b1;
                        m_data_reg.found         <= !missed_reg;
                        m_data_reg.freq_out      <= missed_reg ? '0 : freq_sel;
                        m_data_reg.reached_index <= missed_reg ? '0 : walk_index_reg;
                        walk_index_reg           <= '0;
                        missed_reg               <= 1'b0;
                        state_reg                <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `BTKL_ASSERT_NXT(a_emit_returns_root, (state_reg == S_EMIT) && emit_ok, (walk_index_reg == '0) && !missed_reg && m_valid_reg)
    `BTKL_ASSERT_IMP(a_calc_on_live_node, state_reg == S_CALC, !walk_index_reg[TERM_BIT] && !missed_reg)
    `BTKL_ASSERT_IMP(a_miss_is_zero, m_valid_reg && !m_data_reg.found, (m_data_reg.freq_out == '0) && (m_data_reg.reached_index == '0))
    `BTKL_ASSERT_NXT(a_write_keeps_walk, s_fire && (s_data.kind != KIND_KEY), $stable(walk_index_reg) && $stable(missed_reg) && (state_reg == S_IDLE))

endmodule
